>>> design/traffic_rate_smoother_peak_top_defines.svh
// Assertion macros for the traffic rate smoother checker.
// No dependencies; included by the checker file.
`ifndef TRAFFIC_RATE_SMOOTHER_PEAK_TOP_DEFINES_SVH
`define TRAFFIC_RATE_SMOOTHER_PEAK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TRSP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("trsp checker: property failed");

// Next-cycle implication, checked outside reset
`define TRSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("trsp checker: property failed");

`endif

>>> design/trsp_pkg.sv
// Shared constants, state type and control structs for the rate smoother.
// No dependencies.
package trsp_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int DELTA_AW     = $clog2(MAX_WINDOW);
    localparam int HIST_DEPTH   = 1024;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int SAMPLE_W     = HIST_AW + 1;
    localparam int WIN_W        = 7;
    localparam int TOTAL_W      = 48;
    localparam int DELTA_W      = 32;
    localparam int SMOOTH_W     = 40;
    localparam int ACC_W        = DELTA_W + DELTA_AW;
    localparam int DIVIDEND_W   = ACC_W + 8;
    localparam int CNT_W        = 10;
    localparam int PEAK_FACTOR  = 10;
    localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 7'd30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_PEAK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic sum_run;
        logic div_load;
        logic div_step;
        logic peak_load;
        logic peak_run;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic peak_done;
        logic out_busy;
    } sts_t;

endpackage

>>> design/trsp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module trsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/trsp_ctrl.sv
// Sequencer for the rate smoother: sum, divide, peak walk, output.
// Depends on trsp_pkg.
module trsp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  trsp_pkg::sts_t sts,
    output trsp_pkg::cmd_t cmd
);
    import trsp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_run = 1'b1;
                if (sts.sum_done) begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.peak_load = 1'b1;
                    state_next    = ST_PEAK;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_PEAK: begin
                cmd.peak_run = 1'b1;
                if (sts.peak_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the previous result has gone
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/trsp_datapath.sv
// Datapath: delta rings, running sum, serial divider, history rings, peak walk.
// Depends on trsp_pkg and trsp_ram.
module trsp_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  trsp_pkg::cmd_t                   cmd,
    output trsp_pkg::sts_t                   sts,
    input  logic                             cfg_wr_en,
    input  logic [trsp_pkg::WIN_W-1:0]       cfg_wr_data,
    input  logic [trsp_pkg::TOTAL_W-1:0]     s_rx_total,
    input  logic [trsp_pkg::TOTAL_W-1:0]     s_tx_total,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [trsp_pkg::SMOOTH_W-1:0]    m_rx_smoothed,
    output logic [trsp_pkg::SMOOTH_W-1:0]    m_tx_smoothed,
    output logic [trsp_pkg::SMOOTH_W-1:0]    m_rx_peak,
    output logic [trsp_pkg::SMOOTH_W-1:0]    m_tx_peak
);
    import trsp_pkg::*;

    localparam int DIV_STEPS = DIVIDEND_W;

    function automatic logic [DELTA_W-1:0] clamp_delta(
        input logic [TOTAL_W-1:0] now_v,
        input logic [TOTAL_W-1:0] last_v
    );
        logic [TOTAL_W-1:0] diff;
        diff = now_v - last_v;
        if (now_v <= last_v) begin
            return '0;
        end else if (diff[TOTAL_W-1:DELTA_W] != '0) begin
            return '1;
        end else begin
            return diff[DELTA_W-1:0];
        end
    endfunction

    logic [WIN_W-1:0]      window_reg;
    logic [TOTAL_W-1:0]    rx_last_reg, tx_last_reg;
    logic [DELTA_AW-1:0]   dslot_reg;
    logic [HIST_AW-1:0]    hslot_reg;
    logic [SAMPLE_W-1:0]   samples_reg;
    logic [WIN_W-1:0]      n_reg;
    logic [CNT_W-1:0]      look_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  rd_vld_reg;
    logic [ACC_W-1:0]      rx_acc_reg, tx_acc_reg;
    logic [DIVIDEND_W-1:0] rx_q_reg, tx_q_reg;
    logic [WIN_W-1:0]      rx_rem_reg, tx_rem_reg;
    logic [SMOOTH_W-1:0]   rx_sm_reg, tx_sm_reg;
    logic [SMOOTH_W-1:0]   rx_best_reg, tx_best_reg;
    logic                  m_valid_reg;
    logic [SMOOTH_W-1:0]   m_rx_sm_reg, m_tx_sm_reg, m_rx_pk_reg, m_tx_pk_reg;

    logic [WIN_W-1:0]      w_eff;
    logic [SAMPLE_W-1:0]   samples_next;
    logic [SAMPLE_W-1:0]   prior;
    logic [CNT_W-1:0]      look_cap;
    logic [DELTA_W-1:0]    rx_delta, tx_delta;
    logic                  sum_issue, peak_issue;
    logic [DELTA_W-1:0]    rx_drd, tx_drd;
    logic [SMOOTH_W-1:0]   rx_hrd, tx_hrd;
    logic [WIN_W:0]        rx_trial, tx_trial;
    logic                  rx_bit, tx_bit;

    always_comb begin
        if (window_reg == '0) begin
            w_eff = WIN_W'(1);
        end else if (window_reg > WIN_W'(MAX_WINDOW)) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_eff = window_reg;
        end
    end

    assign samples_next = (samples_reg == SAMPLE_W'(HIST_DEPTH)) ? samples_reg
                                                                 : samples_reg + 1'b1;
    assign prior    = samples_next - 1'b1;
    assign look_cap = CNT_W'(w_eff * PEAK_FACTOR);
    assign rx_delta = clamp_delta(s_rx_total, rx_last_reg);
    assign tx_delta = clamp_delta(s_tx_total, tx_last_reg);

    assign sum_issue  = cmd.sum_run && (cnt_reg < CNT_W'(n_reg));
    assign peak_issue = cmd.peak_run && (cnt_reg <= look_reg);

    // one restoring divide step per cycle, both directions side by side
    assign rx_trial = {rx_rem_reg, rx_q_reg[DIVIDEND_W-1]};
    assign tx_trial = {tx_rem_reg, tx_q_reg[DIVIDEND_W-1]};
    assign rx_bit   = rx_trial >= {1'b0, n_reg};
    assign tx_bit   = tx_trial >= {1'b0, n_reg};

    assign sts.sum_done  = (cnt_reg == CNT_W'(n_reg)) && !rd_vld_reg;
    assign sts.div_done  = (cnt_reg == CNT_W'(DIV_STEPS));
    assign sts.peak_done = (cnt_reg > look_reg) && !rd_vld_reg;
    assign sts.out_busy  = m_valid_reg;

    trsp_ram #(.WIDTH(DELTA_W), .DEPTH(MAX_WINDOW)) u_rx_delta (
        .aclk(aclk), .we(cmd.accept), .waddr(dslot_reg), .wdata(rx_delta),
        .raddr(dslot_reg - cnt_reg[DELTA_AW-1:0]), .rdata(rx_drd)
    );
    trsp_ram #(.WIDTH(DELTA_W), .DEPTH(MAX_WINDOW)) u_tx_delta (
        .aclk(aclk), .we(cmd.accept), .waddr(dslot_reg), .wdata(tx_delta),
        .raddr(dslot_reg - cnt_reg[DELTA_AW-1:0]), .rdata(tx_drd)
    );
    trsp_ram #(.WIDTH(SMOOTH_W), .DEPTH(HIST_DEPTH)) u_rx_hist (
        .aclk(aclk), .we(cmd.peak_load), .waddr(hslot_reg),
        .wdata(rx_q_reg[SMOOTH_W-1:0]),
        .raddr(hslot_reg - cnt_reg[HIST_AW-1:0]), .rdata(rx_hrd)
    );
    trsp_ram #(.WIDTH(SMOOTH_W), .DEPTH(HIST_DEPTH)) u_tx_hist (
        .aclk(aclk), .we(cmd.peak_load), .waddr(hslot_reg),
        .wdata(tx_q_reg[SMOOTH_W-1:0]),
        .raddr(hslot_reg - cnt_reg[HIST_AW-1:0]), .rdata(tx_hrd)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= DEFAULT_WINDOW;
            rx_last_reg <= '0;
            tx_last_reg <= '0;
            dslot_reg   <= '0;
            hslot_reg   <= '0;
            samples_reg <= '0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                rx_last_reg <= s_rx_total;
                tx_last_reg <= s_tx_total;
                samples_reg <= samples_next;
            end
            if (cmd.accept || cmd.div_load) begin
                cnt_reg <= '0;
            end else if (cmd.peak_load) begin
                cnt_reg <= CNT_W'(1);
            end else if (sum_issue || peak_issue || cmd.div_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_vld_reg <= sum_issue || peak_issue;
            if (cmd.out_load) begin
                dslot_reg   <= dslot_reg + 1'b1;
                hslot_reg   <= hslot_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            n_reg      <= (samples_next < SAMPLE_W'(w_eff)) ? WIN_W'(samples_next) : w_eff;
            look_reg   <= (prior < SAMPLE_W'(look_cap)) ? CNT_W'(prior) : look_cap;
            rx_acc_reg <= '0;
            tx_acc_reg <= '0;
        end else if (cmd.sum_run && rd_vld_reg) begin
            rx_acc_reg <= rx_acc_reg + ACC_W'(rx_drd);
            tx_acc_reg <= tx_acc_reg + ACC_W'(tx_drd);
        end
        if (cmd.div_load) begin
            rx_q_reg   <= {rx_acc_reg, 8'd0};
            tx_q_reg   <= {tx_acc_reg, 8'd0};
            rx_rem_reg <= '0;
            tx_rem_reg <= '0;
        end else if (cmd.div_step) begin
            rx_q_reg   <= {rx_q_reg[DIVIDEND_W-2:0], rx_bit};
            tx_q_reg   <= {tx_q_reg[DIVIDEND_W-2:0], tx_bit};
            rx_rem_reg <= rx_bit ? WIN_W'(rx_trial - {1'b0, n_reg}) : rx_trial[WIN_W-1:0];
            tx_rem_reg <= tx_bit ? WIN_W'(tx_trial - {1'b0, n_reg}) : tx_trial[WIN_W-1:0];
        end
        if (cmd.peak_load) begin
            rx_sm_reg   <= rx_q_reg[SMOOTH_W-1:0];
            tx_sm_reg   <= tx_q_reg[SMOOTH_W-1:0];
            rx_best_reg <= '0;
            tx_best_reg <= '0;
        end else if (cmd.peak_run && rd_vld_reg) begin
            if (rx_hrd > rx_best_reg) begin
                rx_best_reg <= rx_hrd;
            end
            if (tx_hrd > tx_best_reg) begin
                tx_best_reg <= tx_hrd;
            end
        end
        if (cmd.out_load) begin
            m_rx_sm_reg <= rx_sm_reg;
            m_tx_sm_reg <= tx_sm_reg;
            m_rx_pk_reg <= rx_best_reg;
            m_tx_pk_reg <= tx_best_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rx_smoothed = m_rx_sm_reg;
    assign m_tx_smoothed = m_tx_sm_reg;
    assign m_rx_peak     = m_rx_pk_reg;
    assign m_tx_peak     = m_tx_pk_reg;

endmodule

>>> design/traffic_rate_smoother_peak_top.sv
// Top level of the traffic rate smoother with windowed peak.
// Depends on trsp_pkg, trsp_ctrl, trsp_datapath, trsp_ram.
//
//  channel  | ports                              | width
//  ---------+------------------------------------+---------------
//  request  | s_valid/s_ready, s_rx/tx_total     | 48 + 48
//  result   | m_valid/m_ready, m_rx/tx_smoothed, | 4 x 40
//           | m_rx/tx_peak                       |
//  config   | cfg_wr_en, cfg_wr_data             | 7
//
// One request sums n deltas (n = averaged deltas, up to 64), runs the serial
// divider, then walks the history RAM for the peak over L earlier entries (L up
// to 640), and ends in the output state.
// Reset is synchronous; all stores start empty and a fill count keeps reads
// inside written entries, so no clearing pass is needed.
// A stalled result stays in the output register; the next request is
// processed and waits in the output state until that register is free.
module traffic_rate_smoother_peak_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [trsp_pkg::TOTAL_W-1:0]  s_rx_total,
    input  logic [trsp_pkg::TOTAL_W-1:0]  s_tx_total,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [trsp_pkg::SMOOTH_W-1:0] m_rx_smoothed,
    output logic [trsp_pkg::SMOOTH_W-1:0] m_tx_smoothed,
    output logic [trsp_pkg::SMOOTH_W-1:0] m_rx_peak,
    output logic [trsp_pkg::SMOOTH_W-1:0] m_tx_peak,
    input  logic                          cfg_wr_en,
    input  logic [trsp_pkg::WIN_W-1:0]    cfg_wr_data
);
    import trsp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    trsp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    trsp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_rx_total(s_rx_total), .s_tx_total(s_tx_total),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rx_smoothed(m_rx_smoothed), .m_tx_smoothed(m_tx_smoothed),
        .m_rx_peak(m_rx_peak), .m_tx_peak(m_tx_peak)
    );

endmodule

>>> design/trsp_checker.sv
// Port-level checker for the rate smoother, bound to the top level.
// Depends on traffic_rate_smoother_peak_top_defines.svh.
`include "traffic_rate_smoother_peak_top_defines.svh"

module trsp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready
);

    // a stalled result is held
    `TRSP_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid)
    // one request at a time: busy straight after taking one
    `TRSP_ASSERT_NEXT(a_busy_after_req, s_valid && s_ready, !s_ready)
    // a taken result is never followed straight away by a new one
    `TRSP_ASSERT_NEXT(a_no_back_to_back, m_valid && m_ready, !m_valid)
    // a new result shows up only while the block is ready for a request
    `TRSP_ASSERT_IMPL(a_rise_idle, $rose(m_valid), s_ready)

endmodule

bind traffic_rate_smoother_peak_top trsp_checker u_trsp_checker (.*);
